// ===== hdl/wirr_pkg.sv =====
// shared types and constants for the weighted interleaved round-robin scheduler
package wirr_pkg;

   localparam int MODE_W      = 2;
   localparam int QIDX_W      = 2;
   localparam int SERVED_W    = 2;
   localparam int NUMQ_W      = 3;
   localparam int WEIGHT_W    = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 8;

   localparam int NUM_WEIGHT_REGS = 4;

   localparam logic [MODE_W-1:0] MODE_ENQUEUE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SELECT  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_QUEUES = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WEIGHT_Q0  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WEIGHT_Q3  = 3'd4;

   localparam logic [NUMQ_W-1:0]   NUM_QUEUES_RESET = 3'd4;
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET     = 8'd1;
   // queues without a weight register get this weight
   localparam logic [WEIGHT_W-1:0] WEIGHT_ABSENT    = 8'd1;

   typedef struct packed {
      logic load;
      logic wrap;
      logic step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic wrap_needed;
      logic scan_step;
      logic out_free;
   } sts_type;

endpackage

// ===== hdl/wirr_controller.sv =====
// request sequencer: accept, wrap and scan steps, result write
module wirr_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  wirr_pkg::sts_type sts,
   output wirr_pkg::cmd_type cmd
);
   import wirr_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_BUSY
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   assign req_tready = ready_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && ready_ff) begin
               cmd.load = 1'b1;
               state_in = ST_BUSY;
            end
         end
         ST_BUSY: begin
            priority if (sts.wrap_needed) begin
               cmd.wrap = 1'b1;
            end else if (sts.scan_step) begin
               cmd.step = 1'b1;
            end else if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      ready_in = (state_in == ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.wrap, cmd.step, cmd.finish}))
      else $error("more than one datapath command at once");

   a_idle_only_load: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (!cmd.wrap && !cmd.step && !cmd.finish))
      else $error("work command while accepting requests");

endmodule

// ===== hdl/wirr_datapath.sv =====
// scheduler state, config registers, scan index and result register
module wirr_datapath #(
   parameter int NQ         = 4,
   parameter int COUNT_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  wirr_pkg::cmd_type                    cmd,
   output wirr_pkg::sts_type                    sts,
   input  logic [wirr_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  logic [wirr_pkg::MODE_W-1:0]          req_tuser,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [wirr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [wirr_pkg::CSR_DATA_W-1:0]      csr_data,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [wirr_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic                                 rsp_tuser
);
   import wirr_pkg::*;

   localparam int PTR_BITS   = $clog2(NQ);
   localparam int IDX_BITS   = PTR_BITS + 1;
   localparam int N_BITS     = $clog2(NQ + 1);
   localparam int TALLY_BITS = $clog2(2 * NQ + 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   // config registers
   logic [NUMQ_W-1:0]   num_queues_ff;
   logic [WEIGHT_W-1:0] weight_ff [NUM_WEIGHT_REGS];
   logic [WEIGHT_W-1:0] weight_vec [NQ];

   // scheduler state
   logic [COUNT_BITS-1:0] count_ff  [NQ];
   logic [COUNT_BITS-1:0] count_in  [NQ];
   logic [WEIGHT_W-1:0]   credit_ff [NQ];
   logic [WEIGHT_W-1:0]   credit_in [NQ];
   logic [NQ-1:0]         done_ff, done_in;
   logic [PTR_BITS-1:0]   pointer_ff, pointer_in;
   logic [TALLY_BITS-1:0] tally_ff, tally_in;

   // per-request working registers
   logic [MODE_W-1:0]   mode_ff;
   logic [IDX_BITS-1:0] idx_ff, idx_in;
   logic [N_BITS-1:0]   scanned_ff, scanned_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_granted_ff, rsp_granted_in;
   logic [SERVED_W-1:0] rsp_served_ff, rsp_served_in;
   logic                rsp_reloaded_ff, rsp_reloaded_in;

   logic [N_BITS-1:0]     n_active;
   logic                  in_range;
   logic [PTR_BITS-1:0]   idx_lo;
   logic [COUNT_BITS-1:0] cur_count;
   logic [WEIGHT_W-1:0]   cur_credit;
   logic                  cur_done;
   logic                  is_select;
   logic [IDX_BITS-1:0]   idx_inc;
   logic                  cred_one;
   logic [TALLY_BITS-1:0] tally_mid;
   logic                  reload;
   logic                  grant;

   for (genvar g = 0; g < NQ; g++) begin : g_weight
      if (g < NUM_WEIGHT_REGS) begin : g_reg
         assign weight_vec[g] = weight_ff[g];
      end else begin : g_absent
         assign weight_vec[g] = WEIGHT_ABSENT;
      end
   end

   always_comb begin
      if (num_queues_ff == '0) begin
         n_active = N_BITS'(1);
      end else if (num_queues_ff > NUMQ_W'(NQ)) begin
         n_active = N_BITS'(NQ);
      end else begin
         n_active = N_BITS'(num_queues_ff);
      end
   end

   assign in_range   = idx_ff < IDX_BITS'(NQ);
   assign idx_lo     = idx_ff[PTR_BITS-1:0];
   assign cur_count  = in_range ? count_ff[idx_lo] : '0;
   assign cur_credit = in_range ? credit_ff[idx_lo] : '0;
   assign cur_done   = in_range ? done_ff[idx_lo] : 1'b0;
   assign is_select  = (mode_ff == MODE_SELECT);
   assign idx_inc    = idx_ff + IDX_BITS'(1);

   assign cred_one  = (cur_credit == WEIGHT_W'(1));
   assign tally_mid = tally_ff + TALLY_BITS'(cred_one);
   assign reload    = tally_mid >= TALLY_BITS'(n_active);
   assign grant     = (scanned_ff != n_active);

   // pointer left beyond a reduced queue count is folded back one subtract a cycle
   assign sts.wrap_needed = is_select && (idx_ff >= IDX_BITS'(n_active));
   assign sts.scan_step   = is_select && !sts.wrap_needed && (scanned_ff < n_active)
                            && ((cur_count == '0) || cur_done);
   assign sts.out_free    = !rsp_valid_ff || rsp_tready;

   always_comb begin
      count_in        = count_ff;
      credit_in       = credit_ff;
      done_in         = done_ff;
      pointer_in      = pointer_ff;
      tally_in        = tally_ff;
      idx_in          = idx_ff;
      scanned_in      = scanned_ff;
      rsp_granted_in  = rsp_granted_ff;
      rsp_served_in   = rsp_served_ff;
      rsp_reloaded_in = rsp_reloaded_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;

      if (cmd.load) begin
         scanned_in = '0;
         if (req_tuser == MODE_ENQUEUE) begin
            idx_in = IDX_BITS'(req_tdata[QIDX_W-1:0]);
         end else begin
            idx_in = IDX_BITS'(pointer_ff) + IDX_BITS'(1);
         end
      end

      if (cmd.wrap) begin
         idx_in = idx_ff - IDX_BITS'(n_active);
      end

      if (cmd.step) begin
         // an empty queue found on the scan closes its round
         if (in_range && !cur_done && cur_count == '0) begin
            tally_in        = tally_ff + TALLY_BITS'(1);
            done_in[idx_lo] = 1'b1;
         end
         idx_in     = (idx_inc >= IDX_BITS'(n_active)) ? '0 : idx_inc;
         scanned_in = scanned_ff + N_BITS'(1);
      end

      if (cmd.finish) begin
         rsp_valid_in    = 1'b1;
         rsp_granted_in  = 1'b0;
         rsp_served_in   = '0;
         rsp_reloaded_in = 1'b0;
         unique case (mode_ff)
            MODE_ENQUEUE: begin
               if (in_range && cur_count != COUNT_MAX) begin
                  count_in[idx_lo] = cur_count + COUNT_BITS'(1);
               end
            end
            MODE_RESTART: begin
               for (int q = 0; q < NQ; q++) begin
                  credit_in[q] = '0;
               end
               done_in = '0;
            end
            MODE_SELECT: begin
               tally_in = tally_mid;
               if (in_range) begin
                  if (cred_one) begin
                     done_in[idx_lo] = 1'b1;
                  end
                  if (cur_credit != '0) begin
                     credit_in[idx_lo] = cur_credit - WEIGHT_W'(1);
                  end
                  if (grant && cur_count != '0) begin
                     count_in[idx_lo] = cur_count - COUNT_BITS'(1);
                  end
               end
               if (reload) begin
                  tally_in = '0;
                  for (int q = 0; q < NQ; q++) begin
                     if (N_BITS'(q) < n_active) begin
                        credit_in[q] = weight_vec[q];
                        done_in[q]   = 1'b0;
                     end
                  end
               end
               pointer_in      = idx_lo;
               rsp_granted_in  = grant;
               rsp_served_in   = grant ? SERVED_W'(idx_ff) : '0;
               rsp_reloaded_in = reload;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_queues_ff <= NUM_QUEUES_RESET;
         for (int w = 0; w < NUM_WEIGHT_REGS; w++) begin
            weight_ff[w] <= WEIGHT_RESET;
         end
         for (int q = 0; q < NQ; q++) begin
            count_ff[q]  <= '0;
            credit_ff[q] <= '0;
         end
         done_ff      <= '0;
         pointer_ff   <= '0;
         tally_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_NUM_QUEUES) begin
               num_queues_ff <= csr_data[NUMQ_W-1:0];
            end else if (csr_index >= CSR_WEIGHT_Q0 && csr_index <= CSR_WEIGHT_Q3) begin
               weight_ff[2'(csr_index - CSR_WEIGHT_Q0)] <= csr_data[WEIGHT_W-1:0];
            end
         end
         count_ff     <= count_in;
         credit_ff    <= credit_in;
         done_ff      <= done_in;
         pointer_ff   <= pointer_in;
         tally_ff     <= tally_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_tuser;
      end
      idx_ff          <= idx_in;
      scanned_ff      <= scanned_in;
      rsp_granted_ff  <= rsp_granted_in;
      rsp_served_ff   <= rsp_served_in;
      rsp_reloaded_ff <= rsp_reloaded_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_granted_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - SERVED_W - 1)'(0), rsp_reloaded_ff, rsp_served_ff};

   a_finish_shows_result: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_tvalid)
      else $error("result register not loaded after finish");

   a_no_grant_zero_queue: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[SERVED_W-1:0] == '0))
      else $error("served queue nonzero without a grant");

   a_non_select_quiet: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && mode_ff != MODE_SELECT) |=> (!rsp_tuser && rsp_tdata == '0))
      else $error("non-select request produced a grant or reload");

endmodule

// ===== hdl/weighted_interleaved_rr_scheduler_unit.sv =====
// top level of the weighted interleaved round-robin scheduler
//
// Requests enter on req_: req_tuser carries the mode (enqueue, select, restart)
// and req_tdata the queue index for enqueue. Every request yields exactly one
// response on rsp_: rsp_tuser is the grant flag, rsp_tdata holds the served
// queue and the round-reload flag. Registers (queue count in use, weights of
// queues 0 to 3) are written on csr_; the user must do so only while no
// request is in flight, as the block itself does not enforce this. A select
// first folds back a pointer left beyond a reduced queue count, then scans
// past empty or finished queues, up to the queue count in use; the scan
// visits one queue per cycle. A new request is taken the cycle after the
// previous response is written.
// Reset clears all counts, credits, done flags, the pointer and the tally and
// loads the default registers; requests are accepted in the first cycle
// after reset. The response sits in an output register: while the receiver
// stalls, one further request is accepted and held until that register frees.
module weighted_interleaved_rr_scheduler_unit #(
   parameter int NQ         = 4,
   parameter int COUNT_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [wirr_pkg::REQ_TDATA_W-1:0] req_tdata,   // [1:0] queue_index, rest zero
   input  logic [wirr_pkg::MODE_W-1:0]      req_tuser,   // [1:0] mode
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [wirr_pkg::RSP_TDATA_W-1:0] rsp_tdata,   // [1:0] served_queue, [2] round_reloaded
   output logic                             rsp_tuser,   // [0] granted
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [wirr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [wirr_pkg::CSR_DATA_W-1:0]  csr_data
);
   import wirr_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   wirr_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   wirr_datapath #(
      .NQ         (NQ),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
